FILE: rtl/tgad_pkg.sv
package tgad_pkg;

   // Stream field widths.
   localparam int unsigned BYTE_W     = 8;
   localparam int unsigned DIM_W      = 16;
   localparam int unsigned PIXCOUNT_W = 32;
   localparam int unsigned CHAN_W     = 3;
   localparam int unsigned STATUS_W   = 2;
   localparam int unsigned REQ_DATA_W = 8;
   localparam int unsigned RSP_DATA_W = 80;

   // Header layout: index of the last header byte and the bytes that matter.
   localparam logic [4:0] HDR_ID_LEN    = 5'd0;
   localparam logic [4:0] HDR_IMG_TYPE  = 5'd2;
   localparam logic [4:0] HDR_WIDTH_LO  = 5'd12;
   localparam logic [4:0] HDR_WIDTH_HI  = 5'd13;
   localparam logic [4:0] HDR_HEIGHT_LO = 5'd14;
   localparam logic [4:0] HDR_HEIGHT_HI = 5'd15;
   localparam logic [4:0] HDR_BPP       = 5'd16;
   localparam logic [4:0] HDR_LAST      = 5'd17;

   // Image type for run-length encoded true color.
   localparam logic [7:0] IMG_TYPE_RLE = 8'd10;

   // Supported pixel depths.
   localparam logic [7:0] BPP_16 = 8'd16;
   localparam logic [7:0] BPP_24 = 8'd24;
   localparam logic [7:0] BPP_32 = 8'd32;

   // Result status codes.
   localparam logic [STATUS_W-1:0] STATUS_OK          = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_UNSUPPORTED = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_CLIPPED     = 2'd2;

   // Output channel counts.
   localparam logic [CHAN_W-1:0] CHANNELS_RGB  = 3'd3;
   localparam logic [CHAN_W-1:0] CHANNELS_RGBA = 3'd4;

   // One decoded result as it leaves the parser.
   typedef struct packed {
      logic [BYTE_W-1:0]   red;
      logic [BYTE_W-1:0]   green;
      logic [BYTE_W-1:0]   blue;
      logic [BYTE_W-1:0]   alpha;
      logic [BYTE_W-1:0]   run_length;
      logic                last_pixel;
      logic [STATUS_W-1:0] status;
      logic [CHAN_W-1:0]   channels;
      logic [DIM_W-1:0]    image_width;
      logic [DIM_W-1:0]    image_height;
   } result_type;

endpackage

FILE: rtl/tga_image_decoder_top.sv
// A byte goes from the input register through the parser into the result register.
// Throughput: one byte per cycle unless output stalls; at most one result per byte.
// The rate is set by the single parser step between the input and result registers.
// Reset is synchronous and active high; it returns the parser to the header phase.
module tga_image_decoder_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [tgad_pkg::REQ_DATA_W-1:0] req_tdata,  // [7:0] data_byte
   input  logic                            req_tuser,  // [0] start_of_file
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [7:0] red, [15:8] green, [23:16] blue, [31:24] alpha, [39:32] run_length,
   // [42:40] channels, [58:43] image_width, [74:59] image_height, [79:75] zero
   output logic [tgad_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                            rsp_tlast,  // last_pixel
   output logic [tgad_pkg::STATUS_W-1:0]   rsp_tuser   // [1:0] status
);
   import tgad_pkg::*;

   logic                 in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0]    in_byte_ff;
   logic                 in_sof_ff;
   logic                 advance;
   logic                 res_valid;
   result_type           res;
   logic                 rsp_valid_ff, rsp_valid_in;
   result_type           rsp_data_ff;

   // The held byte is processed whenever the result register can take its result.
   assign advance     = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready  = !in_valid_ff || advance;
   assign in_valid_in = (req_tvalid && req_tready) || (in_valid_ff && !advance);

   always_comb begin
      if (advance) begin
         rsp_valid_in = res_valid;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata[BYTE_W-1:0];
         in_sof_ff  <= req_tuser;
      end
   end

   tgad_parser u_parser (
      .clock         (clock),
      .reset         (reset),
      .step          (advance),
      .data_byte     (in_byte_ff),
      .start_of_file (in_sof_ff),
      .res_valid     (res_valid),
      .res           (res)
   );

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (advance && res_valid) begin
         rsp_data_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0,
                        rsp_data_ff.image_height,
                        rsp_data_ff.image_width,
                        rsp_data_ff.channels,
                        rsp_data_ff.run_length,
                        rsp_data_ff.alpha,
                        rsp_data_ff.blue,
                        rsp_data_ff.green,
                        rsp_data_ff.red};
   assign rsp_tlast  = rsp_data_ff.last_pixel;
   assign rsp_tuser  = rsp_data_ff.status;

endmodule

FILE: rtl/tgad_parser.sv
module tgad_parser (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        step,
   input  logic [tgad_pkg::BYTE_W-1:0] data_byte,
   input  logic                        start_of_file,
   output logic                        res_valid,
   output tgad_pkg::result_type        res
);
   import tgad_pkg::*;

   typedef enum logic [2:0] {
      PH_HEADER,
      PH_IDSKIP,
      PH_RAW,
      PH_RLEHDR,
      PH_RLECOL,
      PH_DONE,
      PH_ERROR
   } phase_type;

   phase_type               phase_ff, phase_in, phase_cur;
   logic [4:0]              header_count_ff, header_count_in, header_count_cur;
   logic [BYTE_W-1:0]       id_skip_left_ff, id_skip_left_in, id_skip_left_cur;
   logic                    is_rle_ff, is_rle_in, is_rle_cur;
   logic [BYTE_W-1:0]       bpp_ff, bpp_in, bpp_cur;
   logic [DIM_W-1:0]        width_ff, width_in, width_cur;
   logic [DIM_W-1:0]        height_ff, height_in, height_cur;
   logic [PIXCOUNT_W-1:0]   pixels_left_ff, pixels_left_in, pixels_left_cur;
   logic [BYTE_W-1:0]       packet_left_ff, packet_left_in, packet_left_cur;
   logic                    packet_repeat_ff, packet_repeat_in, packet_repeat_cur;
   logic [1:0]              color_idx_ff, color_idx_in, color_idx_cur;
   logic [31:0]             color_buf_ff, color_buf_in, color_buf_cur;

   // Pixel assembly and emission terms shared by the data phases.
   logic [31:0]             buf_new;
   logic [2:0]              bytes_pp;
   logic                    pix_done;
   logic [BYTE_W-1:0]       run_req;
   logic                    more;
   logic                    run_clip;
   logic [BYTE_W-1:0]       run_out;
   logic [PIXCOUNT_W-1:0]   pl_after;
   logic                    img_last;
   logic [15:0]             word16;
   result_type              pix_res;
   logic                    fmt_ok;
   logic                    image_empty;

   // A start-of-file byte sees the parser as if just out of reset.
   always_comb begin
      phase_cur         = start_of_file ? PH_HEADER : phase_ff;
      header_count_cur  = start_of_file ? '0 : header_count_ff;
      id_skip_left_cur  = start_of_file ? '0 : id_skip_left_ff;
      is_rle_cur        = start_of_file ? 1'b0 : is_rle_ff;
      bpp_cur           = start_of_file ? '0 : bpp_ff;
      width_cur         = start_of_file ? '0 : width_ff;
      height_cur        = start_of_file ? '0 : height_ff;
      pixels_left_cur   = start_of_file ? '0 : pixels_left_ff;
      packet_left_cur   = start_of_file ? '0 : packet_left_ff;
      packet_repeat_cur = start_of_file ? 1'b0 : packet_repeat_ff;
      color_idx_cur     = start_of_file ? '0 : color_idx_ff;
      color_buf_cur     = start_of_file ? '0 : color_buf_ff;
   end

   // Merge the incoming byte into the color word and build the pixel result.
   always_comb begin
      buf_new = color_buf_cur;
      case (color_idx_cur)
         2'd0:    buf_new[7:0]   = color_buf_cur[7:0]   | data_byte;
         2'd1:    buf_new[15:8]  = color_buf_cur[15:8]  | data_byte;
         2'd2:    buf_new[23:16] = color_buf_cur[23:16] | data_byte;
         default: buf_new[31:24] = color_buf_cur[31:24] | data_byte;
      endcase

      if (bpp_cur == BPP_16) begin
         bytes_pp = 3'd2;
      end else if (bpp_cur == BPP_32) begin
         bytes_pp = 3'd4;
      end else begin
         bytes_pp = 3'd3;
      end
      pix_done = ({1'b0, color_idx_cur} + 3'd1) >= bytes_pp;

      // Only a repeat packet asks for more than one pixel.
      if (phase_cur == PH_RLECOL && packet_repeat_cur) begin
         run_req = packet_left_cur;
      end else begin
         run_req = 8'd1;
      end
      more = (phase_cur == PH_RLECOL) && !packet_repeat_cur && (packet_left_cur > 8'd1);

      run_clip = {24'd0, run_req} > pixels_left_cur;
      run_out  = run_clip ? pixels_left_cur[BYTE_W-1:0] : run_req;
      pl_after = pixels_left_cur - {24'd0, run_out};
      img_last = (pl_after == '0);

      word16  = buf_new[15:0];
      pix_res = '0;
      if (bpp_cur == BPP_16) begin
         pix_res.blue  = {word16[4:0], 3'b000};
         pix_res.green = {word16[9:5], 3'b000};
         pix_res.red   = {word16[14:10], 3'b000};
      end else begin
         pix_res.blue  = buf_new[7:0];
         pix_res.green = buf_new[15:8];
         pix_res.red   = buf_new[23:16];
         if (bpp_cur == BPP_32) begin
            pix_res.alpha = buf_new[31:24];
         end
      end
      pix_res.run_length   = run_out;
      pix_res.last_pixel   = img_last;
      pix_res.status       = (run_clip || (img_last && more)) ? STATUS_CLIPPED : STATUS_OK;
      pix_res.channels     = (bpp_cur == BPP_32) ? CHANNELS_RGBA : CHANNELS_RGB;
      pix_res.image_width  = width_cur;
      pix_res.image_height = height_cur;
   end

   // Phase sequencing for one byte.
   always_comb begin
      phase_in         = phase_cur;
      header_count_in  = header_count_cur;
      id_skip_left_in  = id_skip_left_cur;
      is_rle_in        = is_rle_cur;
      bpp_in           = bpp_cur;
      width_in         = width_cur;
      height_in        = height_cur;
      pixels_left_in   = pixels_left_cur;
      packet_left_in   = packet_left_cur;
      packet_repeat_in = packet_repeat_cur;
      color_idx_in     = color_idx_cur;
      color_buf_in     = color_buf_cur;
      res_valid        = 1'b0;
      res              = pix_res;

      fmt_ok = (bpp_cur == BPP_24) || (bpp_cur == BPP_32) ||
               (!is_rle_cur && (bpp_cur == BPP_16));
      image_empty = (width_cur == '0) || (height_cur == '0);

      unique case (phase_cur)
         PH_HEADER: begin
            if (header_count_cur < HDR_LAST) begin
               case (header_count_cur)
                  HDR_ID_LEN:    id_skip_left_in = data_byte;
                  HDR_IMG_TYPE:  is_rle_in = (data_byte == IMG_TYPE_RLE);
                  HDR_WIDTH_LO:  width_in[7:0] = data_byte;
                  HDR_WIDTH_HI:  width_in[15:8] = data_byte;
                  HDR_HEIGHT_LO: height_in[7:0] = data_byte;
                  HDR_HEIGHT_HI: height_in[15:8] = data_byte;
                  HDR_BPP:       bpp_in = data_byte;
                  default:       ;
               endcase
               header_count_in = header_count_cur + 5'd1;
            end else if (!fmt_ok) begin
               // Unsupported pixel format: one error result, then idle.
               phase_in         = PH_ERROR;
               res_valid        = 1'b1;
               res              = '0;
               res.status       = STATUS_UNSUPPORTED;
               res.channels     = CHANNELS_RGB;
               res.image_width  = width_cur;
               res.image_height = height_cur;
            end else begin
               pixels_left_in = {16'd0, width_cur} * {16'd0, height_cur};
               if (id_skip_left_cur != '0) begin
                  phase_in = PH_IDSKIP;
               end else begin
                  color_idx_in = '0;
                  color_buf_in = '0;
                  if (image_empty) begin
                     phase_in = PH_DONE;
                  end else begin
                     phase_in = is_rle_cur ? PH_RLEHDR : PH_RAW;
                  end
               end
            end
         end
         PH_IDSKIP: begin
            id_skip_left_in = id_skip_left_cur - 8'd1;
            if (id_skip_left_cur == 8'd1) begin
               color_idx_in = '0;
               color_buf_in = '0;
               if (pixels_left_cur == '0) begin
                  phase_in = PH_DONE;
               end else begin
                  phase_in = is_rle_cur ? PH_RLEHDR : PH_RAW;
               end
            end
         end
         PH_RAW: begin
            if (pix_done) begin
               res_valid      = 1'b1;
               pixels_left_in = pl_after;
               color_idx_in   = '0;
               color_buf_in   = '0;
               if (img_last) begin
                  phase_in = PH_DONE;
               end
            end else begin
               color_idx_in = color_idx_cur + 2'd1;
               color_buf_in = buf_new;
            end
         end
         PH_RLEHDR: begin
            // Packet header: high bit selects a repeat packet.
            if (data_byte[7]) begin
               packet_repeat_in = 1'b1;
               packet_left_in   = data_byte - 8'd127;
            end else begin
               packet_repeat_in = 1'b0;
               packet_left_in   = data_byte + 8'd1;
            end
            color_idx_in = '0;
            color_buf_in = '0;
            phase_in     = PH_RLECOL;
         end
         PH_RLECOL: begin
            if (pix_done) begin
               res_valid      = 1'b1;
               pixels_left_in = pl_after;
               color_idx_in   = '0;
               color_buf_in   = '0;
               if (img_last) begin
                  phase_in       = PH_DONE;
                  packet_left_in = '0;
               end else if (packet_repeat_cur) begin
                  phase_in       = PH_RLEHDR;
                  packet_left_in = '0;
               end else begin
                  packet_left_in = packet_left_cur - 8'd1;
                  if (packet_left_cur == 8'd1) begin
                     phase_in = PH_RLEHDR;
                  end
               end
            end else begin
               color_idx_in = color_idx_cur + 2'd1;
               color_buf_in = buf_new;
            end
         end
         default: ;
      endcase
   end

   // Parser state, advanced once per processed byte.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_HEADER;
         header_count_ff  <= '0;
         id_skip_left_ff  <= '0;
         is_rle_ff        <= 1'b0;
         bpp_ff           <= '0;
         width_ff         <= '0;
         height_ff        <= '0;
         pixels_left_ff   <= '0;
         packet_left_ff   <= '0;
         packet_repeat_ff <= 1'b0;
         color_idx_ff     <= '0;
         color_buf_ff     <= '0;
      end else if (step) begin
         phase_ff         <= phase_in;
         header_count_ff  <= header_count_in;
         id_skip_left_ff  <= id_skip_left_in;
         is_rle_ff        <= is_rle_in;
         bpp_ff           <= bpp_in;
         width_ff         <= width_in;
         height_ff        <= height_in;
         pixels_left_ff   <= pixels_left_in;
         packet_left_ff   <= packet_left_in;
         packet_repeat_ff <= packet_repeat_in;
         color_idx_ff     <= color_idx_in;
         color_buf_ff     <= color_buf_in;
      end
   end

endmodule
